@@ design/assert_macros.svh @@
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TVSM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define TVSM_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ design/tvsm_pkg.sv @@
// shared types, constants and key function of the translation vector sweep matcher
package tvsm_pkg;

    // command codes
    localparam logic [1:0] CMD_PAT  = 2'd0;
    localparam logic [1:0] CMD_SONG = 2'd1;
    localparam logic [1:0] CMD_RUN  = 2'd2;

    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

    localparam int RESULT_CAP = 64;
    localparam int CNT_SAT    = 127;

    // token that walks down the cell row looking for the smallest key
    typedef struct packed {
        logic               valid;
        logic               found;
        logic signed [31:0] key;
    } scan_t;

    // broadcast from the sequencer to the cells
    typedef struct packed {
        logic        load;
        logic        init;
        logic        upd;
        logic        exhaust;
        logic [21:0] onset;
        logic [6:0]  pitch;
    } bcast_t;

    // translation key of one song note against one pattern note
    function automatic logic signed [31:0] make_key(
        input logic [21:0] so,
        input logic [6:0]  sp,
        input logic [21:0] po,
        input logic [6:0]  pp,
        input logic [21:0] pend,
        input logic [7:0]  offs
    );
        logic signed [25:0] d;
        logic signed [35:0] k;
        d = $signed({4'b0, so}) - $signed({4'b0, po}) + $signed({4'b0, pend});
        k = ($signed({{10{d[25]}}, d}) <<< 8) + $signed({29'b0, sp})
            - $signed({29'b0, pp}) + $signed({28'b0, offs});
        return k[31:0];
    endfunction

endpackage

@@ design/translation_vector_sweep_match_top.sv @@
// top level: note loading, sweep sequencer, cell row, song ram and result register
// loads are taken while idle; a run performs L extractions and may stall on the output,
// where L = pattern length times song length, each found by the min scan down the cell row
// one extraction: scan state, step state (holds on a stall), update state (song ram read)
// results leave through one output register; a match is held back until the next is known
// reset: lengths zero, allowed_errors 64, no result pending; stores need no clearing pass
module translation_vector_sweep_match_top #(
    parameter int PATTERN_MAX  = 64,
    parameter int SONG_MAX     = 4096,
    parameter int PITCH_OFFSET = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [21:0]        note_onset,
    input  logic [6:0]         note_pitch,
    input  logic [15:0]        note_duration,
    input  logic [15:0]        song_id,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               match_valid,
    output logic [15:0]        match_song,
    output logic signed [22:0] match_start,
    output logic signed [23:0] match_end,
    output logic signed [7:0]  transposition,
    output logic [6:0]         match_count,
    output logic               overflow,
    output logic               last
);
    import tvsm_pkg::*;
    `include "assert_macros.svh"

    localparam int PIDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int PLEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int SADDR_W = (SONG_MAX > 1) ? $clog2(SONG_MAX) : 1;
    localparam int SLEN_W  = $clog2(SONG_MAX + 1);
    localparam int TPX_W   = SLEN_W + 1;
    localparam int CNT_RAW = $clog2(PATTERN_MAX * SONG_MAX + 1);
    localparam int CNT_W   = (CNT_RAW > 8) ? CNT_RAW : 8;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INIT_RD = 3'd1;
    localparam logic [2:0] S_INIT_WR = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_STEP    = 3'd4;
    localparam logic [2:0] S_UPD     = 3'd5;
    localparam logic [2:0] S_FINAL   = 3'd6;

    logic [2:0]         state_reg;
    logic [6:0]         ae_reg;
    logic [PLEN_W-1:0]  plen_reg;
    logic [SLEN_W-1:0]  slen_reg;
    logic [21:0]        p0_reg;
    logic [21:0]        pend_reg;
    logic [15:0]        dlast_reg;
    logic [15:0]        sid_reg;
    logic [CNT_W-1:0]   minsz_reg;
    logic signed [23:0] stoff_reg;
    logic [CNT_W-1:0]   loops_reg;
    logic [CNT_W-1:0]   it_reg;
    logic [CNT_W-1:0]   run_reg;
    logic [CNT_W-1:0]   best_reg;
    logic signed [31:0] prev_reg;
    logic [6:0]         nres_reg;
    logic               over_reg;
    logic               pv_reg;
    logic signed [22:0] pst_reg;
    logic signed [23:0] pen_reg;
    logic signed [7:0]  ptr_reg;
    logic [6:0]         pcnt_reg;
    logic               launch_reg;
    logic signed [31:0] hk_reg;
    logic [PIDX_W-1:0]  hi_reg;
    logic [SADDR_W-1:0] ht_reg;
    logic               more_reg;

    logic               out_valid_reg;
    logic               mv_reg;
    logic [15:0]        ms_reg;
    logic signed [22:0] mst_reg;
    logic signed [23:0] men_reg;
    logic signed [7:0]  mtr_reg;
    logic [6:0]         mcnt_reg;
    logic               mov_reg;
    logic               mlast_reg;

    // cell row wiring
    scan_t              sc [PATTERN_MAX+1];
    logic [PIDX_W-1:0]  idx_w [PATTERN_MAX+1];
    logic [SADDR_W-1:0] tp_w [PATTERN_MAX+1];
    logic [PATTERN_MAX:0] scan_vec;
    bcast_t             bc;
    logic [PIDX_W-1:0]  sel_idx;

    // song ram
    logic               ram_we;
    logic [SADDR_W-1:0] ram_waddr;
    logic [SADDR_W-1:0] ram_raddr;
    logic [28:0]        ram_rdata;

    logic               accept;
    logic               out_free;
    logic               pat_ok;
    logic               song_ok;
    logic               same;
    logic               qual;
    logic               keep;
    logic               stall;
    logic [CNT_W-1:0]   run_inc;
    logic [CNT_W-1:0]   ae_ext;
    logic [CNT_W-1:0]   plen_ext;
    logic [CNT_W-1:0]   minsz_calc;
    logic signed [23:0] base;
    logic signed [22:0] m_start;
    logic signed [23:0] m_end;
    logic signed [7:0]  m_tr;
    logic [6:0]         m_cnt;
    logic               more;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign pat_ok   = (plen_reg < PLEN_W'(PATTERN_MAX));
    assign song_ok  = (slen_reg < SLEN_W'(SONG_MAX));

    // broadcast to the cells
    always_comb
    begin
        bc.load    = accept && (cmd == CMD_PAT) && pat_ok;
        bc.init    = (state_reg == S_INIT_WR);
        bc.upd     = (state_reg == S_UPD) && more_reg;
        bc.exhaust = (state_reg == S_UPD) && !more_reg;
        bc.onset   = (state_reg == S_IDLE) ? note_onset : ram_rdata[28:7];
        bc.pitch   = (state_reg == S_IDLE) ? note_pitch : ram_rdata[6:0];
        sel_idx    = (state_reg == S_IDLE) ? plen_reg[PIDX_W-1:0] : hi_reg;
    end

    // scan token enters at the head of the row
    assign sc[0].valid = launch_reg;
    assign sc[0].found = 1'b0;
    assign sc[0].key   = KEY_MAX;
    assign idx_w[0]    = '0;
    assign tp_w[0]     = '0;
    assign scan_vec[0] = sc[0].valid;

    for (genvar g = 0; g < PATTERN_MAX; g++)
    begin : g_cell
        tvsm_cell #(
            .IDX          (g),
            .PIDX_W       (PIDX_W),
            .SADDR_W      (SADDR_W),
            .PITCH_OFFSET (PITCH_OFFSET)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .bc      (bc),
            .sel_idx (sel_idx),
            .pend    (pend_reg),
            .s_in    (sc[g]),
            .idx_in  (idx_w[g]),
            .tp_in   (tp_w[g]),
            .s_out   (sc[g+1]),
            .idx_out (idx_w[g+1]),
            .tp_out  (tp_w[g+1])
        );
        assign scan_vec[g+1] = sc[g+1].valid;
    end

    // song note store
    assign ram_we    = accept && (cmd == CMD_SONG) && song_ok;
    assign ram_waddr = slen_reg[SADDR_W-1:0];
    assign ram_raddr = (state_reg == S_STEP) ? (ht_reg + SADDR_W'(1)) : '0;

    tvsm_ram #(
        .WIDTH (29),
        .DEPTH (SONG_MAX)
    ) u_song_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({note_onset, note_pitch}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // run setup values
    assign ae_ext     = CNT_W'(ae_reg);
    assign plen_ext   = CNT_W'(plen_reg);
    assign minsz_calc = (ae_ext >= plen_ext) ? '0 : (plen_ext - ae_ext);

    // run bookkeeping and match fields of the closing run
    assign same    = (hk_reg == prev_reg);
    assign qual    = !same && (run_reg == best_reg) && (run_reg >= minsz_reg);
    assign keep    = qual && (nres_reg < 7'(RESULT_CAP));
    assign stall   = keep && pv_reg && !out_free;
    assign run_inc = run_reg + CNT_W'(1);
    assign base    = prev_reg[31:8];
    assign m_start = 23'(base + stoff_reg);
    assign m_end   = base + $signed({8'b0, dlast_reg});
    assign m_tr    = prev_reg[7:0] - 8'(PITCH_OFFSET);
    assign m_cnt   = (run_reg >= CNT_W'(CNT_SAT)) ? 7'(CNT_SAT) : 7'(run_inc);
    assign more    = ((TPX_W'(ht_reg) + TPX_W'(1)) < TPX_W'(slen_reg));

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ae_reg        <= 7'd64;
            plen_reg      <= '0;
            slen_reg      <= '0;
            p0_reg        <= '0;
            pend_reg      <= '0;
            dlast_reg     <= '0;
            sid_reg       <= '0;
            minsz_reg     <= '0;
            stoff_reg     <= '0;
            loops_reg     <= '0;
            it_reg        <= '0;
            run_reg       <= '0;
            best_reg      <= CNT_W'(1);
            prev_reg      <= KEY_MIN;
            nres_reg      <= '0;
            over_reg      <= 1'b0;
            pv_reg        <= 1'b0;
            pst_reg       <= '0;
            pen_reg       <= '0;
            ptr_reg       <= '0;
            pcnt_reg      <= '0;
            launch_reg    <= 1'b0;
            hk_reg        <= '0;
            hi_reg        <= '0;
            ht_reg        <= '0;
            more_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            mv_reg        <= 1'b0;
            ms_reg        <= '0;
            mst_reg       <= '0;
            men_reg       <= '0;
            mtr_reg       <= '0;
            mcnt_reg      <= '0;
            mov_reg       <= 1'b0;
            mlast_reg     <= 1'b0;
        end
        else
        begin
            launch_reg <= 1'b0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                ae_reg <= cfg_data;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (cmd)
                            CMD_PAT:
                            begin
                                if (pat_ok)
                                begin
                                    if (plen_reg == '0)
                                    begin
                                        p0_reg <= note_onset;
                                    end
                                    pend_reg  <= note_onset;
                                    dlast_reg <= note_duration;
                                    plen_reg  <= plen_reg + PLEN_W'(1);
                                end
                            end
                            CMD_SONG:
                            begin
                                if (song_ok)
                                begin
                                    slen_reg <= slen_reg + SLEN_W'(1);
                                end
                            end
                            CMD_RUN:
                            begin
                                sid_reg   <= song_id;
                                nres_reg  <= '0;
                                over_reg  <= 1'b0;
                                pv_reg    <= 1'b0;
                                minsz_reg <= minsz_calc;
                                stoff_reg <= $signed({2'b0, p0_reg}) - $signed({2'b0, pend_reg});
                                loops_reg <= CNT_W'(plen_reg * slen_reg);
                                it_reg    <= '0;
                                run_reg   <= '0;
                                best_reg  <= CNT_W'(1);
                                prev_reg  <= KEY_MIN;
                                if ((plen_reg != '0) && (slen_reg != '0))
                                begin
                                    state_reg <= S_INIT_RD;
                                end
                                else
                                begin
                                    state_reg <= S_FINAL;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_INIT_RD:
                begin
                    state_reg <= S_INIT_WR;
                end
                S_INIT_WR:
                begin
                    launch_reg <= 1'b1;
                    state_reg  <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (sc[PATTERN_MAX].valid)
                    begin
                        hk_reg    <= sc[PATTERN_MAX].key;
                        hi_reg    <= idx_w[PATTERN_MAX];
                        ht_reg    <= tp_w[PATTERN_MAX];
                        state_reg <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    if (!stall)
                    begin
                        if (same)
                        begin
                            run_reg <= run_inc;
                            if (run_inc > best_reg)
                            begin
                                best_reg <= run_inc;
                            end
                        end
                        else
                        begin
                            if (qual)
                            begin
                                if (keep)
                                begin
                                    nres_reg <= nres_reg + 7'd1;
                                    // previous match leaves now that it is not the last
                                    if (pv_reg)
                                    begin
                                        out_valid_reg <= 1'b1;
                                        mv_reg        <= 1'b1;
                                        ms_reg        <= sid_reg;
                                        mst_reg       <= pst_reg;
                                        men_reg       <= pen_reg;
                                        mtr_reg       <= ptr_reg;
                                        mcnt_reg      <= pcnt_reg;
                                        mov_reg       <= 1'b0;
                                        mlast_reg     <= 1'b0;
                                    end
                                    pv_reg   <= 1'b1;
                                    pst_reg  <= m_start;
                                    pen_reg  <= m_end;
                                    ptr_reg  <= m_tr;
                                    pcnt_reg <= m_cnt;
                                end
                                else
                                begin
                                    over_reg <= 1'b1;
                                end
                            end
                            prev_reg <= hk_reg;
                            run_reg  <= '0;
                        end
                        more_reg  <= more;
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    it_reg <= it_reg + CNT_W'(1);
                    if ((it_reg + CNT_W'(1)) == loops_reg)
                    begin
                        state_reg <= S_FINAL;
                    end
                    else
                    begin
                        launch_reg <= 1'b1;
                        state_reg  <= S_SCAN;
                    end
                end
                S_FINAL:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        mv_reg        <= pv_reg;
                        ms_reg        <= pv_reg ? sid_reg : '0;
                        mst_reg       <= pv_reg ? pst_reg : '0;
                        men_reg       <= pv_reg ? pen_reg : '0;
                        mtr_reg       <= pv_reg ? ptr_reg : '0;
                        mcnt_reg      <= pv_reg ? pcnt_reg : '0;
                        mov_reg       <= over_reg;
                        mlast_reg     <= 1'b1;
                        pv_reg        <= 1'b0;
                        slen_reg      <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result word
    assign out_valid     = out_valid_reg;
    assign match_valid   = mv_reg;
    assign match_song    = ms_reg;
    assign match_start   = mst_reg;
    assign match_end     = men_reg;
    assign transposition = mtr_reg;
    assign match_count   = mcnt_reg;
    assign overflow      = mov_reg;
    assign last          = mlast_reg;

    // checks
    `TVSM_ASSERT(a_one_token, $onehot0(scan_vec), "more than one scan token in the cell row")
    `TVSM_ASSERT(a_best_ge_run, best_reg >= run_reg, "run count above best count")
    `TVSM_NEVER(a_cap, nres_reg > 7'(RESULT_CAP), "match count above cap")
    `TVSM_ASSERT(a_song_clear, (state_reg == S_FINAL && out_free) |=> (slen_reg == '0),
                 "song length not cleared after run")
endmodule

@@ design/tvsm_ram.sv @@
// generic simple dual port ram with registered read
module tvsm_ram #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 4096
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ design/tvsm_cell.sv @@
// one cell of the row: a pattern note, its song pointer, its current key and a scan stage
module tvsm_cell #(
    parameter int IDX          = 0,
    parameter int PIDX_W       = 6,
    parameter int SADDR_W      = 12,
    parameter int PITCH_OFFSET = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tvsm_pkg::bcast_t     bc,
    input  logic [PIDX_W-1:0]    sel_idx,
    input  logic [21:0]          pend,
    input  tvsm_pkg::scan_t      s_in,
    input  logic [PIDX_W-1:0]    idx_in,
    input  logic [SADDR_W-1:0]   tp_in,
    output tvsm_pkg::scan_t      s_out,
    output logic [PIDX_W-1:0]    idx_out,
    output logic [SADDR_W-1:0]   tp_out
);
    import tvsm_pkg::*;

    logic [21:0]        onset_reg;
    logic [6:0]         pitch_reg;
    logic               active_reg;
    logic [SADDR_W-1:0] tp_reg;
    logic signed [31:0] key_reg;
    scan_t              s_reg;
    logic [PIDX_W-1:0]  idx_reg;
    logic [SADDR_W-1:0] tpo_reg;
    logic signed [31:0] new_key;
    logic               hit;
    logic               take;

    assign hit     = (sel_idx == PIDX_W'(IDX));
    assign new_key = make_key(bc.onset, bc.pitch, onset_reg, pitch_reg, pend,
                              8'(PITCH_OFFSET));
    // lowest index wins on equal keys: replace only on strictly smaller
    assign take    = s_in.valid && active_reg && (!s_in.found || (key_reg < s_in.key));

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            s_reg      <= '0;
        end
        else
        begin
            if (bc.load && hit)
            begin
                active_reg <= 1'b1;
            end
            s_reg.valid <= s_in.valid;
            s_reg.found <= s_in.found | take;
            s_reg.key   <= take ? key_reg : s_in.key;
        end
    end

    // note payload, pointer and key
    always_ff @(posedge clk)
    begin
        if (bc.load && hit)
        begin
            onset_reg <= bc.onset;
            pitch_reg <= bc.pitch;
        end
        if (bc.init)
        begin
            tp_reg  <= '0;
            key_reg <= new_key;
        end
        else if (bc.upd && hit)
        begin
            tp_reg  <= tp_reg + SADDR_W'(1);
            key_reg <= new_key;
        end
        else if (bc.exhaust && hit)
        begin
            key_reg <= KEY_MAX;
        end
        idx_reg <= take ? PIDX_W'(IDX) : idx_in;
        tpo_reg <= take ? tp_reg : tp_in;
    end

    assign s_out   = s_reg;
    assign idx_out = idx_reg;
    assign tp_out  = tpo_reg;
endmodule
